// ===== rtl/core/lgs_pkg.sv =====
// ----------------------------------------------------------------------------
// lgs_pkg: shared definitions for the life generation stepper
// Cell codes, field widths, register indexes and the B3/S23 rule.
// ----------------------------------------------------------------------------
package lgs_pkg;

  localparam int CODE_W       = 2;
  localparam int POP_W        = 13;
  localparam int ROWS_W       = 7;
  localparam int COLS_W       = 8;
  localparam int CFG_AW       = 3;
  localparam int CFG_DW       = 32;
  localparam int REG_IDX_W    = 1;
  localparam int NBR_W        = 4;
  localparam int LGS_MAX_COLS = 128;
  localparam int LGS_MAX_ROWS = 64;
  localparam int MIN_SIZE     = 3;
  localparam int ROWS_RESET   = 40;
  localparam int COLS_RESET   = 100;
  localparam int OUT_DEPTH    = 4;

  localparam logic [POP_W-1:0]  POP_MAX   = 13'd8191;

  localparam logic [CODE_W-1:0] CODE_DEAD  = 2'd0;
  localparam logic [CODE_W-1:0] CODE_ALIVE = 2'd1;
  localparam logic [CODE_W-1:0] CODE_WALL  = 2'd2;
  localparam logic [CODE_W-1:0] CODE_RSVD  = 2'd3;

  localparam logic [REG_IDX_W-1:0] REG_NUM_ROWS = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_NUM_COLS = 1'd1;

  localparam logic [NBR_W-1:0] NBR_SURVIVE = 4'd2;
  localparam logic [NBR_W-1:0] NBR_BIRTH   = 4'd3;

  // one window column, index 0 is the top row
  typedef logic [2:0][CODE_W-1:0] col_t;

  typedef struct packed {
    logic [CODE_W-1:0] next_cell;
    logic [POP_W-1:0]  population;
    logic              last_of_frame;
  } result_t;

  function automatic logic [CODE_W-1:0] life_rule(input logic [CODE_W-1:0] center,
                                                  input logic [NBR_W-1:0]  nbrs);
    logic [CODE_W-1:0] res;
    res = CODE_DEAD;
    if (center == CODE_WALL || center == CODE_RSVD) begin
      res = CODE_WALL;
    end else if (center == CODE_ALIVE) begin
      if (nbrs == NBR_SURVIVE || nbrs == NBR_BIRTH) res = CODE_ALIVE;
    end else if (nbrs == NBR_BIRTH) begin
      res = CODE_ALIVE;
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/lgs_ram.sv =====
// ----------------------------------------------------------------------------
// lgs_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lgs_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/lgs_col_cell.sv =====
// ----------------------------------------------------------------------------
// lgs_col_cell: one column of the 3x3 neighborhood window
// Loads the column of its right neighbor on each shift and counts live cells.
// ----------------------------------------------------------------------------
module lgs_col_cell
  import lgs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       shift,
  input  col_t       load_i,
  output col_t       cells_o,
  output logic [1:0] live_o
);

  col_t cells_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cells_r <= {3{CODE_DEAD}};
    end else if (shift) begin
      cells_r <= load_i;
    end
  end

  assign cells_o = cells_r;
  assign live_o  = 2'(cells_r[0] == CODE_ALIVE) + 2'(cells_r[1] == CODE_ALIVE)
                 + 2'(cells_r[2] == CODE_ALIVE);

endmodule

// ===== rtl/core/lgs_out_fifo.sv =====
// ----------------------------------------------------------------------------
// lgs_out_fifo: result buffer
// Small register FIFO that decouples the window pipeline from the consumer.
// ----------------------------------------------------------------------------
module lgs_out_fifo
  import lgs_pkg::*;
#(
  parameter int DEPTH = OUT_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  result_t                    push_data,
  output logic                       pop_valid,
  input  logic                       pop_ready,
  output result_t                    pop_data,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  result_t         mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            pop;

  assign pop       = pop_valid && pop_ready;
  assign pop_valid = (cnt_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];
  assign count     = cnt_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (!push && pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

// ===== rtl/core/life_generation_stepper.sv =====
// ----------------------------------------------------------------------------
// A result is registered in stage 1, stage 2 and the result FIFO before out_valid.
// Throughput: one cell per cycle while in_ready is high; the line store RAM
//   (one read, one write per cycle) and the three-column-cell window shift set it.
// Reset: synchronous on rst_n; line store entries read as dead until first
//   written (valid bits clear at once, no clearing pass).
// ----------------------------------------------------------------------------
// life_generation_stepper: one B3/S23 generation over a raster cell stream
// Two line stores feed a chain of three column cells forming a 3x3 window;
// each interior cell is emitted with a running population count.
// ----------------------------------------------------------------------------
module life_generation_stepper
  import lgs_pkg::*;
#(
  parameter int MAX_COLS = LGS_MAX_COLS,
  parameter int MAX_ROWS = LGS_MAX_ROWS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CODE_W-1:0] in_cell_code,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CODE_W-1:0] out_next_cell,
  output logic [POP_W-1:0]  out_population,
  output logic              out_last_of_frame,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam int CPW = $clog2(MAX_COLS);
  localparam int RPW = $clog2(MAX_ROWS);
  localparam int CCW = $clog2(MAX_COLS + 1);
  localparam int RCW = $clog2(MAX_ROWS + 1);
  localparam int FCW = $clog2(OUT_DEPTH + 1);

  typedef struct packed {
    logic emit;
    logic last;
    logic first;
  } tag_t;

  // configuration
  logic [ROWS_W-1:0]    num_rows_r;
  logic [COLS_W-1:0]    num_cols_r;
  logic                 cfg_wr;
  logic [REG_IDX_W-1:0] cfg_idx;
  logic [RCW-1:0]       rows_eff;
  logic [CCW-1:0]       cols_eff;

  // position and front stage
  logic [RPW-1:0]    row_r, row_nxt;
  logic [CPW-1:0]    col_r, col_nxt;
  logic              in_acc;
  logic              row_last, col_last;
  logic [CODE_W-1:0] code_a;
  tag_t              tag_a;

  // stage 1: line store data available
  logic              s1_vld_r;
  logic [CODE_W-1:0] s1_code_r;
  logic [CPW-1:0]    s1_col_r;
  logic              s1_init_r;
  tag_t              s1_tag_r;
  logic [MAX_COLS-1:0]   line_vld_r;
  logic [2*CODE_W-1:0]   ram_rdata;
  logic [2*CODE_W-1:0]   line_rd;

  // stage 2: window evaluation
  logic              s2_vld_r;
  tag_t              s2_tag_r;
  col_t              cell_load [3];
  col_t              cell_q    [3];
  logic [1:0]        cell_live [3];
  logic [NBR_W-1:0]  nbr_cnt;
  logic [CODE_W-1:0] next_code;
  logic [POP_W-1:0]  live_r, live_base, live_inc;

  result_t         push_data;
  result_t         pop_data;
  logic            push;
  logic [FCW-1:0]  fifo_cnt;
  logic [FCW-1:0]  pending;

  // ---------------- configuration port ----------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[CFG_AW-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_rows_r <= ROWS_W'(ROWS_RESET);
      num_cols_r <= COLS_W'(COLS_RESET);
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_NUM_ROWS: num_rows_r <= cfg_pwdata[ROWS_W-1:0];
        REG_NUM_COLS: num_cols_r <= cfg_pwdata[COLS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_NUM_ROWS: cfg_prdata = CFG_DW'(num_rows_r);
      REG_NUM_COLS: cfg_prdata = CFG_DW'(num_cols_r);
      default:      cfg_prdata = '0;
    endcase
  end

  // clamp sizes into [3, MAX]
  always_comb begin
    if (num_rows_r < ROWS_W'(MIN_SIZE))     rows_eff = RCW'(MIN_SIZE);
    else if (int'(num_rows_r) > MAX_ROWS)   rows_eff = RCW'(MAX_ROWS);
    else                                    rows_eff = RCW'(num_rows_r);
    if (num_cols_r < COLS_W'(MIN_SIZE))     cols_eff = CCW'(MIN_SIZE);
    else if (int'(num_cols_r) > MAX_COLS)   cols_eff = CCW'(MAX_COLS);
    else                                    cols_eff = CCW'(num_cols_r);
  end

  // ---------------- raster position ----------------
  assign pending  = fifo_cnt + FCW'(s1_vld_r && s1_tag_r.emit)
                  + FCW'(s2_vld_r && s2_tag_r.emit);
  assign in_ready = (pending < FCW'(OUT_DEPTH));
  assign in_acc   = in_valid && in_ready;

  assign row_last = ((RCW+1)'(row_r) + 1'b1) >= (RCW+1)'(rows_eff);
  assign col_last = ((CCW+1)'(col_r) + 1'b1) >= (CCW+1)'(cols_eff);

  assign code_a     = (in_cell_code == CODE_RSVD) ? CODE_WALL : in_cell_code;
  assign tag_a.emit  = (row_r >= RPW'(2)) && (col_r >= CPW'(2));
  assign tag_a.last  = row_last && col_last;
  assign tag_a.first = (row_r == '0) && (col_r == '0);

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (cfg_wr) begin
      row_nxt = '0;
      col_nxt = '0;
    end else if (in_acc) begin
      if (col_last) begin
        col_nxt = '0;
        row_nxt = row_last ? '0 : row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  // ---------------- line stores ----------------
  // entry = {older row, newer row}; read at the transfer, rewritten in the cycle after
  lgs_ram #(
    .WIDTH (2 * CODE_W),
    .DEPTH (MAX_COLS)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_vld_r),
    .waddr (s1_col_r),
    .wdata ({line_rd[CODE_W-1:0], s1_code_r}),
    .raddr (col_r),
    .rdata (ram_rdata)
  );

  assign line_rd = s1_init_r ? ram_rdata : {CODE_DEAD, CODE_DEAD};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_vld_r <= '0;
      s1_vld_r   <= 1'b0;
      s2_vld_r   <= 1'b0;
    end else begin
      if (s1_vld_r) line_vld_r[s1_col_r] <= 1'b1;
      s1_vld_r <= in_acc;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_code_r <= code_a;
      s1_col_r  <= col_r;
      s1_init_r <= line_vld_r[col_r];
      s1_tag_r  <= tag_a;
    end
    if (s1_vld_r) s2_tag_r <= s1_tag_r;
  end

  // ---------------- window: chain of column cells ----------------
  assign cell_load[2] = {s1_code_r, line_rd[CODE_W-1:0], line_rd[2*CODE_W-1:CODE_W]};
  assign cell_load[1] = cell_q[2];
  assign cell_load[0] = cell_q[1];

  for (genvar k = 0; k < 3; k++) begin : g_col
    lgs_col_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .shift   (s1_vld_r),
      .load_i  (cell_load[k]),
      .cells_o (cell_q[k]),
      .live_o  (cell_live[k])
    );
  end

  // drop the center from the live count
  assign nbr_cnt = NBR_W'(cell_live[0]) + NBR_W'(cell_live[1]) + NBR_W'(cell_live[2])
                 - NBR_W'(cell_q[1][1] == CODE_ALIVE);
  assign next_code = life_rule(cell_q[1][1], nbr_cnt);

  assign live_base = s2_tag_r.first ? '0 : live_r;
  assign live_inc  = (next_code == CODE_ALIVE && live_base < POP_MAX)
                   ? live_base + 1'b1 : live_base;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= '0;
    end else if (cfg_wr) begin
      live_r <= '0;
    end else if (s2_vld_r) begin
      live_r <= s2_tag_r.emit ? live_inc : live_base;
    end
  end

  // ---------------- result buffer ----------------
  assign push                    = s2_vld_r && s2_tag_r.emit;
  assign push_data.next_cell     = next_code;
  assign push_data.population    = live_inc;
  assign push_data.last_of_frame = s2_tag_r.last;

  lgs_out_fifo #(
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop_valid (out_valid),
    .pop_ready (out_ready),
    .pop_data  (pop_data),
    .count     (fifo_cnt)
  );

  assign out_next_cell     = pop_data.next_cell;
  assign out_population    = pop_data.population;
  assign out_last_of_frame = pop_data.last_of_frame;

endmodule

// ===== rtl/core/lgs_checker.sv =====
// ----------------------------------------------------------------------------
// lgs_checker: port-level checks for the life generation stepper
// Watches the result channel over time; bound to the top level.
// ----------------------------------------------------------------------------
module lgs_checker
  import lgs_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CODE_W-1:0] out_next_cell,
  input logic [POP_W-1:0]  out_population,
  input logic              out_last_of_frame
);

  // no result may survive a reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // stalled result holds until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_next_cell)
      && $stable(out_population) && $stable(out_last_of_frame))
    else $error("stalled result changed");

  a_code_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_next_cell != CODE_RSVD)
    else $error("reserved cell code on output");

  // a live cell is always counted in the population it carries
  a_pop_live: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_next_cell == CODE_ALIVE |-> out_population != '0)
    else $error("live cell with zero population");

endmodule

bind life_generation_stepper lgs_checker u_lgs_checker (.*);

// ===== dv/life_check_pkg.sv =====
// ----------------------------------------------------------------------------
// life_check_pkg: next-generation tracking for the life generation stepper
// Follows the accepted cell stream with its own line stores, window and
// frame position, predicts every emitted interior cell with its running
// population and last-of-frame flag, and compares what the block returns.
// ----------------------------------------------------------------------------
package life_check_pkg;
  import lgs_pkg::*;

  class generation_tracker;
    logic [CODE_W-1:0] older_row [LGS_MAX_COLS];
    logic [CODE_W-1:0] newer_row [LGS_MAX_COLS];
    logic [CODE_W-1:0] win [3][3];
    int unsigned       row_pos;
    int unsigned       col_pos;
    logic [POP_W-1:0]  live_count;
    logic [ROWS_W-1:0] rows_reg;
    logic [COLS_W-1:0] cols_reg;
    result_t           next_gen_q [$];
    int unsigned       n_checked;
    int unsigned       n_errors;

    function new();
      foreach (older_row[i]) begin
        older_row[i] = CODE_DEAD;
        newer_row[i] = CODE_DEAD;
      end
      foreach (win[i, j]) win[i][j] = CODE_DEAD;
      row_pos    = 0;
      col_pos    = 0;
      live_count = '0;
      rows_reg   = ROWS_W'(ROWS_RESET);
      cols_reg   = COLS_W'(COLS_RESET);
      n_checked  = 0;
      n_errors   = 0;
    endfunction

    static function int unsigned clamp_dim(int unsigned v, int unsigned hi);
      if (v < MIN_SIZE) return MIN_SIZE;
      if (v > hi) return hi;
      return v;
    endfunction

    function int unsigned pending();
      return next_gen_q.size();
    endfunction

    function void flag(string msg);
      n_errors++;
      if (n_errors <= 10) $display("ERROR: %s", msg);
    endfunction

    // Any register write restarts the frame; the line stores keep their contents.
    function void write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_DW-1:0] data);
      if (idx == REG_NUM_ROWS) begin
        rows_reg = data[ROWS_W-1:0];
      end else if (idx == REG_NUM_COLS) begin
        cols_reg = data[COLS_W-1:0];
      end else begin
        return;
      end
      row_pos    = 0;
      col_pos    = 0;
      live_count = '0;
    endfunction

    function void note_cell(logic [CODE_W-1:0] code);
      int unsigned       nrows;
      int unsigned       ncols;
      int unsigned       nbrs;
      logic [CODE_W-1:0] cur_code;
      logic [CODE_W-1:0] center;
      logic [CODE_W-1:0] nxt;
      result_t           res;
      nrows    = clamp_dim(rows_reg, LGS_MAX_ROWS);
      ncols    = clamp_dim(cols_reg, LGS_MAX_COLS);
      cur_code = (code == CODE_RSVD) ? CODE_WALL : code;
      if (row_pos == 0 && col_pos == 0) live_count = '0;

      // shift the window left and pull in the new column
      for (int k = 0; k < 3; k++) begin
        win[k][0] = win[k][1];
        win[k][1] = win[k][2];
      end
      win[0][2]          = older_row[col_pos];
      win[1][2]          = newer_row[col_pos];
      win[2][2]          = cur_code;
      older_row[col_pos] = newer_row[col_pos];
      newer_row[col_pos] = cur_code;

      if (row_pos >= 2 && col_pos >= 2) begin
        nbrs = 0;
        for (int i = 0; i < 3; i++) begin
          for (int j = 0; j < 3; j++) begin
            if (!(i == 1 && j == 1) && win[i][j] == CODE_ALIVE) nbrs++;
          end
        end
        center = win[1][1];
        if (center == CODE_WALL || center == CODE_RSVD) begin
          nxt = CODE_WALL;
        end else if (center == CODE_ALIVE) begin
          nxt = (nbrs == NBR_SURVIVE || nbrs == NBR_BIRTH) ? CODE_ALIVE : CODE_DEAD;
        end else begin
          nxt = (nbrs == NBR_BIRTH) ? CODE_ALIVE : CODE_DEAD;
        end
        if (nxt == CODE_ALIVE && live_count != POP_MAX) live_count++;
        res.next_cell     = nxt;
        res.population    = live_count;
        res.last_of_frame = (row_pos + 1 >= nrows) && (col_pos + 1 >= ncols);
        next_gen_q.push_back(res);
      end

      col_pos++;
      if (col_pos >= ncols) begin
        col_pos = 0;
        row_pos++;
        if (row_pos >= nrows) row_pos = 0;
      end
    endfunction

    function void check_cell(logic [CODE_W-1:0] next_cell, logic [POP_W-1:0] population,
                             logic last_of_frame);
      result_t want;
      n_checked++;
      if (next_gen_q.size() == 0) begin
        flag($sformatf("unexpected result %0d: next_cell %0d population %0d last %0d",
                       n_checked, next_cell, population, last_of_frame));
        return;
      end
      want = next_gen_q.pop_front();
      if (want.next_cell !== next_cell || want.population !== population ||
          want.last_of_frame !== last_of_frame) begin
        flag($sformatf({"result %0d: expected next_cell %0d population %0d last %0d, ",
                        "got next_cell %0d population %0d last %0d"},
                       n_checked, want.next_cell, want.population, want.last_of_frame,
                       next_cell, population, last_of_frame));
      end
    endfunction

    function void close_out();
      if (next_gen_q.size() != 0)
        flag($sformatf("%0d expected results never arrived", next_gen_q.size()));
    endfunction
  endclass

endpackage

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for the life generation stepper
// Drives raster cell streams through the valid/ready input under several
// grid sizes set over the APB port, with random gaps and stalls on both
// sides and one long result stall, and checks every emitted cell against
// the generation tracker.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lgs_pkg::*;
  import life_check_pkg::*;

  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned HOLD_AT_RESULT = 30;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned CELL_TARGET    = 1200;
  localparam int unsigned QUIET_FROM     = 1050;
  localparam int unsigned RUN_LIMIT_NS   = 4_000_000;

  // three 3x3 frames: survival, birth past wall and code-3 neighbors,
  // code-3 center under a full neighborhood
  localparam logic [CODE_W-1:0] DIRECTED_CELLS [27] = '{
    CODE_ALIVE, CODE_ALIVE, CODE_DEAD,
    CODE_DEAD,  CODE_ALIVE, CODE_DEAD,
    CODE_DEAD,  CODE_DEAD,  CODE_DEAD,
    CODE_ALIVE, CODE_ALIVE, CODE_ALIVE,
    CODE_WALL,  CODE_DEAD,  CODE_RSVD,
    CODE_WALL,  CODE_RSVD,  CODE_WALL,
    CODE_ALIVE, CODE_ALIVE, CODE_ALIVE,
    CODE_ALIVE, CODE_RSVD,  CODE_ALIVE,
    CODE_ALIVE, CODE_ALIVE, CODE_ALIVE
  };

  logic              clk;
  logic              rst_n             = 1'b0;
  logic              in_valid          = 1'b0;
  logic              in_ready;
  logic [CODE_W-1:0] in_cell_code      = CODE_DEAD;
  logic              out_valid;
  logic              out_ready         = 1'b0;
  logic [CODE_W-1:0] out_next_cell;
  logic [POP_W-1:0]  out_population;
  logic              out_last_of_frame;
  logic              cfg_psel          = 1'b0;
  logic              cfg_penable       = 1'b0;
  logic              cfg_pwrite        = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr         = '0;
  logic [CFG_DW-1:0] cfg_pwdata        = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  generation_tracker tracker = new();
  int unsigned       cells_sent  = 0;
  bit                quiet_tail  = 1'b0;
  bit                sender_calm = 1'b0;

  life_generation_stepper dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_cell_code      (in_cell_code),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_next_cell     (out_next_cell),
    .out_population    (out_population),
    .out_last_of_frame (out_last_of_frame),
    .cfg_psel          (cfg_psel),
    .cfg_penable       (cfg_penable),
    .cfg_pwrite        (cfg_pwrite),
    .cfg_paddr         (cfg_paddr),
    .cfg_pwdata        (cfg_pwdata),
    .cfg_prdata        (cfg_prdata),
    .cfg_pready        (cfg_pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) tracker.note_cell(in_cell_code);
    if (rst_n && out_valid && out_ready)
      tracker.check_cell(out_next_cell, out_population, out_last_of_frame);
  end

  // Leave valid up across back-to-back transfers; drop it only for a gap.
  task automatic push_cell(input logic [CODE_W-1:0] code);
    int unsigned gap;
    if (!quiet_tail && !sender_calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 16);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_cell_code <= code;
    do @(posedge clk); while (!in_ready);
    cells_sent++;
  endtask

  task automatic stream_frame(input int unsigned nr, input int unsigned nc,
                              input int unsigned count);
    int unsigned       alive_pct;
    int unsigned       odd_pct;
    int unsigned       roll;
    bit                walled;
    logic [CODE_W-1:0] code;
    alive_pct   = $urandom_range(5, 70);
    odd_pct     = $urandom_range(0, 15);
    walled      = $urandom_range(0, 1);
    sender_calm = ($urandom_range(0, 3) == 0);
    for (int unsigned i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      if (walled && (i / nc == 0 || i % nc == 0 || i / nc + 1 == nr || i % nc + 1 == nc)) begin
        code = CODE_WALL;
      end else if (roll < odd_pct) begin
        code = ($urandom_range(0, 1) != 0) ? CODE_WALL : CODE_RSVD;
      end else if (roll < odd_pct + alive_pct) begin
        code = CODE_ALIVE;
      end else begin
        code = CODE_DEAD;
      end
      push_cell(code);
    end
  endtask

  // Setup cycle then access cycle; psel stays up between chained writes.
  task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DW-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_AW'({idx, 2'b00});
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    tracker.write_reg(idx, data);
  endtask

  task automatic apply_size(input logic [ROWS_W-1:0] rows_raw,
                            input logic [COLS_W-1:0] cols_raw);
    logic [CFG_DW-1:0] data;
    // junk in the upper bits must be ignored
    data               = $urandom();
    data[ROWS_W-1:0]   = rows_raw;
    reg_write(REG_NUM_ROWS, data);
    data               = $urandom();
    data[COLS_W-1:0]   = cols_raw;
    reg_write(REG_NUM_COLS, data);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Drain every expected result, then give cells without a result time to clear.
  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int unsigned rows_raw;
    int unsigned cols_raw;
    int unsigned nr;
    int unsigned nc;
    int unsigned frames;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // sizes below range clamp to 3x3
    apply_size(ROWS_W'(1), COLS_W'(2));
    foreach (DIRECTED_CELLS[i]) push_cell(DIRECTED_CELLS[i]);
    settle();

    apply_size(ROWS_W'(127), COLS_W'(3));
    stream_frame(LGS_MAX_ROWS, 3, LGS_MAX_ROWS * 3);
    settle();
    apply_size(ROWS_W'(2), COLS_W'(255));
    stream_frame(3, LGS_MAX_COLS, 3 * LGS_MAX_COLS);
    settle();
    apply_size(ROWS_W'(LGS_MAX_ROWS), COLS_W'(LGS_MAX_COLS));
    stream_frame(LGS_MAX_ROWS, LGS_MAX_COLS, 2 * LGS_MAX_COLS + 14);
    settle();

    while (cells_sent < CELL_TARGET) begin
      case ($urandom_range(0, 7))
        0: begin
          rows_raw = $urandom_range(0, 2);
          cols_raw = $urandom_range(0, 2);
        end
        1: begin
          rows_raw = MIN_SIZE;
          cols_raw = $urandom_range(16, 40);
        end
        2: begin
          rows_raw = $urandom_range(12, 20);
          cols_raw = MIN_SIZE;
        end
        default: begin
          rows_raw = $urandom_range(3, 8);
          cols_raw = $urandom_range(3, 10);
        end
      endcase
      if (cells_sent >= QUIET_FROM) quiet_tail = 1'b1;
      apply_size(ROWS_W'(rows_raw), COLS_W'(cols_raw));
      nr     = generation_tracker::clamp_dim(rows_raw, LGS_MAX_ROWS);
      nc     = generation_tracker::clamp_dim(cols_raw, LGS_MAX_COLS);
      frames = $urandom_range(1, 3);
      repeat (frames) stream_frame(nr, nc, nr * nc);
      // break off mid-frame; the next write restarts it
      if ($urandom_range(0, 2) == 0) stream_frame(nr, nc, $urandom_range(1, nr * nc - 1));
      settle();
    end

    tracker.close_out();
    if (tracker.n_errors == 0) begin
      $display("life_generation_stepper test passed");
    end else begin
      $display("life_generation_stepper test failed");
    end
    $finish;
  end

  initial begin : result_drain
    int unsigned span;
    bit          hold_done;
    hold_done = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (!hold_done && tracker.n_checked >= HOLD_AT_RESULT) begin
        // long stall so the block backs up into its input
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        span = $urandom_range(1, 16);
        repeat (span) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        span = $urandom_range(1, 40);
        repeat (span) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("life_generation_stepper test failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/lgs_pkg.sv
rtl/core/lgs_ram.sv
rtl/core/lgs_col_cell.sv
rtl/core/lgs_out_fifo.sv
rtl/core/life_generation_stepper.sv
rtl/core/lgs_checker.sv
dv/life_check_pkg.sv
dv/tb_top.sv
